[src/hsv_saturation_value_adjust_top_assert.svh]
// Assertion macros used by the checker file of the color adjust block.
`ifndef HSV_SATURATION_VALUE_ADJUST_TOP_ASSERT_SVH
`define HSV_SATURATION_VALUE_ADJUST_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HSVA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define HSVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/hsva_pkg.sv]
// Types, constants and helper functions of the color adjust block.
package hsva_pkg;

    localparam int CH_BITS   = 8;
    localparam int HUE_BITS  = 11;
    localparam int GAIN_BITS = 12;
    localparam int OFF_BITS  = 9;
    localparam int REM_BITS  = 17;
    localparam int QUO_BITS  = 9;

    localparam logic [HUE_BITS-1:0] HUE_BASE_RED_POS = 11'd0;
    localparam logic [HUE_BITS-1:0] HUE_BASE_RED_NEG = 11'd1536;
    localparam logic [HUE_BITS-1:0] HUE_BASE_GREEN   = 11'd512;
    localparam logic [HUE_BITS-1:0] HUE_BASE_BLUE    = 11'd1024;

    // Configuration register indexes
    localparam logic [1:0] CFG_SAT_GAIN = 2'd0;
    localparam logic [1:0] CFG_SAT_OFF  = 2'd1;
    localparam logic [1:0] CFG_VAL_GAIN = 2'd2;
    localparam logic [1:0] CFG_VAL_OFF  = 2'd3;

    typedef struct packed {
        logic [CH_BITS-1:0] in_red;
        logic [CH_BITS-1:0] in_green;
        logic [CH_BITS-1:0] in_blue;
        logic [CH_BITS-1:0] in_alpha;
    } t_pixel_in;

    typedef struct packed {
        logic [CH_BITS-1:0] out_red;
        logic [CH_BITS-1:0] out_green;
        logic [CH_BITS-1:0] out_blue;
        logic [CH_BITS-1:0] out_alpha;
    } t_pixel_out;

    // Item state carried through the two dividers
    typedef struct packed {
        logic                valid;
        logic [REM_BITS-1:0] rem_s;
        logic [CH_BITS-1:0]  den_s;
        logic [QUO_BITS-1:0] quo_s;
        logic [REM_BITS-1:0] rem_h;
        logic [CH_BITS-1:0]  den_h;
        logic [QUO_BITS-1:0] quo_h;
        logic [HUE_BITS-1:0] h_base;
        logic                h_neg;
        logic                grey;
        logic [CH_BITS-1:0]  val;
        logic [CH_BITS-1:0]  alpha;
    } t_div_pipe;

    // Divide by 255: reciprocal estimate by 257/65536, then one correction
    function automatic logic [CH_BITS-1:0] div255(input logic [15:0] m);
        logic [24:0] prod;
        logic [8:0]  est;
        logic [16:0] rr;
        prod = {9'd0, m} + {1'b0, m, 8'd0};
        est  = prod[24:16];
        rr   = {1'b0, m} - ({8'd0, est} * 17'd255);
        if (rr >= 17'd255) begin
            est = est + 9'd1;
        end
        return est[7:0];
    endfunction

endpackage

[src/hsva_div_stage.sv]
// Three restoring division steps for saturation and hue, one register stage.
module hsva_div_stage #(
    parameter int TOP_BIT = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  hsva_pkg::t_div_pipe   i_pipe,
    output hsva_pkg::t_div_pipe   o_pipe
);

    hsva_pkg::t_div_pipe n_pipe;
    hsva_pkg::t_div_pipe r_pipe;

    // Subtract shifted divisors, set quotient bits
    always_comb begin
        logic [hsva_pkg::REM_BITS-1:0] sh;
        n_pipe = i_pipe;
        for (int j = 0; j < 3; j++) begin
            sh = hsva_pkg::REM_BITS'({9'd0, n_pipe.den_s} << (TOP_BIT - j));
            if (n_pipe.rem_s >= sh) begin
                n_pipe.rem_s = n_pipe.rem_s - sh;
                n_pipe.quo_s = n_pipe.quo_s | (9'd1 << (TOP_BIT - j));
            end
            sh = hsva_pkg::REM_BITS'({9'd0, n_pipe.den_h} << (TOP_BIT - j));
            if (n_pipe.rem_h >= sh) begin
                n_pipe.rem_h = n_pipe.rem_h - sh;
                n_pipe.quo_h = n_pipe.quo_h | (9'd1 << (TOP_BIT - j));
            end
        end
    end

    // Advance valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else if (i_en) begin
            r_pipe.valid <= n_pipe.valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe.rem_s  <= n_pipe.rem_s;
            r_pipe.den_s  <= n_pipe.den_s;
            r_pipe.quo_s  <= n_pipe.quo_s;
            r_pipe.rem_h  <= n_pipe.rem_h;
            r_pipe.den_h  <= n_pipe.den_h;
            r_pipe.quo_h  <= n_pipe.quo_h;
            r_pipe.h_base <= n_pipe.h_base;
            r_pipe.h_neg  <= n_pipe.h_neg;
            r_pipe.grey   <= n_pipe.grey;
            r_pipe.val    <= n_pipe.val;
            r_pipe.alpha  <= n_pipe.alpha;
        end
    end

    assign o_pipe = r_pipe;

endmodule

[src/hsva_hsv2rgb.sv]
// Saturation and value adjustment and HSV to RGB conversion, four stages.
module hsva_hsv2rgb (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  hsva_pkg::t_div_pipe   i_pipe,
    input  logic [11:0]           i_sat_gain,
    input  logic [8:0]            i_sat_off,
    input  logic [11:0]           i_val_gain,
    input  logic [8:0]            i_val_off,
    output logic                  o_valid,
    output hsva_pkg::t_pixel_out  o_pixel
);

    function automatic logic [7:0] scale_clamp(input logic [7:0] x, input logic [11:0] gain,
                                               input logic [8:0] off);
        logic [19:0]        prod;
        logic signed [13:0] sum;
        prod = ({12'd0, x} * {8'd0, gain}) + 20'd128;
        sum  = $signed({2'b00, prod[19:8]}) + $signed({{5{off[8]}}, off});
        if (sum < 14'sd0) begin
            return 8'd0;
        end else if (sum > 14'sd255) begin
            return 8'd255;
        end
        return sum[7:0];
    endfunction

    // Stage A: hue, adjusted saturation and value
    logic        r_a_valid;
    logic [10:0] r_a_hue;
    logic [7:0]  r_a_sat, r_a_val, r_a_alpha;
    logic [10:0] n_a_hue;
    logic [7:0]  n_a_sat;

    always_comb begin
        if (i_pipe.grey) begin
            n_a_hue = 11'd0;
            n_a_sat = 8'd0;
        end else begin
            n_a_hue = i_pipe.h_neg ? i_pipe.h_base - {2'b00, i_pipe.quo_h}
                                   : i_pipe.h_base + {2'b00, i_pipe.quo_h};
            n_a_sat = i_pipe.quo_s[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_hue   <= n_a_hue;
            r_a_sat   <= scale_clamp(n_a_sat, i_sat_gain, i_sat_off);
            r_a_val   <= scale_clamp(i_pipe.val, i_val_gain, i_val_off);
            r_a_alpha <= i_pipe.alpha;
        end
    end

    // Stage B: first products
    logic        r_b_valid;
    logic [2:0]  r_b_sec;
    logic [7:0]  r_b_val, r_b_alpha;
    logic [15:0] r_b_ps, r_b_pt, r_b_pp;
    logic [16:0] n_b_pt;

    assign n_b_pt = {9'd0, r_a_sat} * {8'd0, 9'd256 - {1'b0, r_a_hue[7:0]}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_sec   <= r_a_hue[10:8];
            r_b_val   <= r_a_val;
            r_b_alpha <= r_a_alpha;
            r_b_ps    <= {8'd0, r_a_sat} * {8'd0, r_a_hue[7:0]};
            r_b_pt    <= n_b_pt[15:0];
            r_b_pp    <= {8'd0, r_a_val} * {8'd0, 8'd255 - r_a_sat};
        end
    end

    // Stage C: scaled numerators, reduced by 256
    logic        r_c_valid;
    logic [2:0]  r_c_sec;
    logic [7:0]  r_c_val, r_c_alpha;
    logic [15:0] r_c_mq, r_c_mt, r_c_mp;
    logic [23:0] n_c_qn, n_c_tn;

    assign n_c_qn = ({16'd0, r_b_val} * {8'd0, 16'd65280 - r_b_ps}) + 24'd32640;
    assign n_c_tn = ({16'd0, r_b_val} * {8'd0, 16'd65280 - r_b_pt}) + 24'd32640;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_sec   <= r_b_sec;
            r_c_val   <= r_b_val;
            r_c_alpha <= r_b_alpha;
            r_c_mq    <= n_c_qn[23:8];
            r_c_mt    <= n_c_tn[23:8];
            r_c_mp    <= r_b_pp + 16'd127;
        end
    end

    // Stage D: divide by 255 and pick channels by sector
    logic                 r_d_valid;
    hsva_pkg::t_pixel_out r_d_pixel;
    hsva_pkg::t_pixel_out n_d_pixel;
    logic [7:0]           n_p, n_q, n_t;

    always_comb begin
        n_p = hsva_pkg::div255(r_c_mp);
        n_q = hsva_pkg::div255(r_c_mq);
        n_t = hsva_pkg::div255(r_c_mt);
        n_d_pixel.out_alpha = r_c_alpha;
        case (r_c_sec)
            3'd0: begin
                n_d_pixel.out_red = r_c_val; n_d_pixel.out_green = n_t;
                n_d_pixel.out_blue = n_p;
            end
            3'd1: begin
                n_d_pixel.out_red = n_q; n_d_pixel.out_green = r_c_val;
                n_d_pixel.out_blue = n_p;
            end
            3'd2: begin
                n_d_pixel.out_red = n_p; n_d_pixel.out_green = r_c_val;
                n_d_pixel.out_blue = n_t;
            end
            3'd3: begin
                n_d_pixel.out_red = n_p; n_d_pixel.out_green = n_q;
                n_d_pixel.out_blue = r_c_val;
            end
            3'd4: begin
                n_d_pixel.out_red = n_t; n_d_pixel.out_green = n_p;
                n_d_pixel.out_blue = r_c_val;
            end
            default: begin
                n_d_pixel.out_red = r_c_val; n_d_pixel.out_green = n_p;
                n_d_pixel.out_blue = n_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_pixel <= n_d_pixel;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_pipe.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    assign o_valid = r_d_valid;
    assign o_pixel = r_d_pixel;

endmodule

[src/hsv_saturation_value_adjust_top.sv]
// Throughput: one item per cycle while the output is not stalled; the
// eight-stage pipeline advances as a whole. The dividers resolve three
// quotient bits per stage, which sets the depth. Reset (synchronous, active
// low) clears all valid bits and loads unity gains and zero offsets.
module hsv_saturation_value_adjust_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  hsva_pkg::t_pixel_in   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output hsva_pkg::t_pixel_out  o_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [11:0]           i_cfg_data
);

    logic [11:0] r_sat_gain, r_val_gain;
    logic [8:0]  r_sat_off, r_val_off;
    logic        en;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_gain <= 12'd256;
            r_sat_off  <= 9'd0;
            r_val_gain <= 12'd256;
            r_val_off  <= 9'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hsva_pkg::CFG_SAT_GAIN: r_sat_gain <= i_cfg_data;
                hsva_pkg::CFG_SAT_OFF:  r_sat_off  <= i_cfg_data[8:0];
                hsva_pkg::CFG_VAL_GAIN: r_val_gain <= i_cfg_data;
                hsva_pkg::CFG_VAL_OFF:  r_val_off  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Pipeline moves unless the output holds an item that is stalled
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Stage 1: max, min, spread and divider setup
    hsva_pkg::t_div_pipe n_s1, r_s1;
    logic [7:0] mx, mn, d, up, down, diff;
    logic [10:0] base;

    always_comb begin
        logic [7:0] r, g, b;
        r = i_data.in_red;
        g = i_data.in_green;
        b = i_data.in_blue;
        mn = (r < g) ? r : g;
        mn = (b < mn) ? b : mn;
        if (r >= g && r >= b) begin
            mx = r; up = g; down = b;
            base = (g >= b) ? hsva_pkg::HUE_BASE_RED_POS : hsva_pkg::HUE_BASE_RED_NEG;
        end else if (g >= b) begin
            mx = g; up = b; down = r; base = hsva_pkg::HUE_BASE_GREEN;
        end else begin
            mx = b; up = r; down = g; base = hsva_pkg::HUE_BASE_BLUE;
        end
        d    = mx - mn;
        diff = (up >= down) ? up - down : down - up;
        n_s1.valid  = i_valid;
        n_s1.rem_s  = {1'b0, ({8'd0, d} * 16'd255) + {9'd0, mx[7:1]}};
        n_s1.den_s  = mx;
        n_s1.quo_s  = 9'd0;
        n_s1.rem_h  = {1'b0, {diff, 8'd0} + {9'd0, d[7:1]}};
        n_s1.den_h  = d;
        n_s1.quo_h  = 9'd0;
        n_s1.h_base = base;
        n_s1.h_neg  = (up < down);
        n_s1.grey   = (d == 8'd0);
        n_s1.val    = mx;
        n_s1.alpha  = i_data.in_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (en) begin
            r_s1.valid <= n_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1.rem_s  <= n_s1.rem_s;
            r_s1.den_s  <= n_s1.den_s;
            r_s1.quo_s  <= n_s1.quo_s;
            r_s1.rem_h  <= n_s1.rem_h;
            r_s1.den_h  <= n_s1.den_h;
            r_s1.quo_h  <= n_s1.quo_h;
            r_s1.h_base <= n_s1.h_base;
            r_s1.h_neg  <= n_s1.h_neg;
            r_s1.grey   <= n_s1.grey;
            r_s1.val    <= n_s1.val;
            r_s1.alpha  <= n_s1.alpha;
        end
    end

    // Stages 2 to 4: quotient bits 8..6, 5..3, 2..0
    hsva_pkg::t_div_pipe s2, s3, s4;

    hsva_div_stage #(.TOP_BIT(8)) u_div_hi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_pipe(r_s1), .o_pipe(s2)
    );
    hsva_div_stage #(.TOP_BIT(5)) u_div_mid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_pipe(s2), .o_pipe(s3)
    );
    hsva_div_stage #(.TOP_BIT(2)) u_div_lo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_pipe(s3), .o_pipe(s4)
    );

    // Stages 5 to 8: adjust and convert back
    hsva_hsv2rgb u_hsv2rgb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_pipe     (s4),
        .i_sat_gain (r_sat_gain),
        .i_sat_off  (r_sat_off),
        .i_val_gain (r_val_gain),
        .i_val_off  (r_val_off),
        .o_valid    (o_valid),
        .o_pixel    (o_data)
    );

endmodule

[src/hsva_checker.sv]
// Port-level checks of the color adjust block, bound to its top level.
`include "hsv_saturation_value_adjust_top_assert.svh"

module hsva_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input hsva_pkg::t_pixel_in   i_data,
    input logic                  o_valid,
    input logic                  i_stall,
    input hsva_pkg::t_pixel_out  o_data
);

    // Hold a stalled result
    `HSVA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    // Stall input only when the output is stalled
    `HSVA_ASSERT_NOW(a_stall_src, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    // Keep accepting while the output is free
    `HSVA_ASSERT_NOW(a_no_stall, i_clk, i_rst_n, !i_stall, !o_stall)
    // Deliver alpha unchanged at the output for an accepted item that meets no stall
    `HSVA_ASSERT_NOW(a_alpha_pass, i_clk, i_rst_n, $past(i_valid && !o_stall, 8) && !$past(o_stall, 1) && !$past(o_stall, 2) && !$past(o_stall, 3) && !$past(o_stall, 4) && !$past(o_stall, 5) && !$past(o_stall, 6) && !$past(o_stall, 7), o_valid && (o_data.out_alpha == $past(i_data.in_alpha, 8)))

endmodule

bind hsv_saturation_value_adjust_top hsva_checker u_hsva_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

[dv/hsv_saturation_value_adjust_top_test.sv]
// Self-checking testbench for the HSV saturation and value adjust block.
module hsv_saturation_value_adjust_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMAX = 255;
    localparam int LIMIT_CYCLES = 200000;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    hsva_pkg::t_pixel_in i_data;
    hsva_pkg::t_pixel_out o_data;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [11:0] i_cfg_data;

    hsv_saturation_value_adjust_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predictor copy of the gain and offset registers
    int unsigned sat_gain, val_gain;
    int sat_off, val_off;

    hsva_pkg::t_pixel_in pending_pixels[$];
    hsva_pkg::t_pixel_out expected_pixels[$];
    int mismatches, checked, cycles;
    bit sender_idle;
    bit in_taken;

    function automatic int unsigned rdiv(longint unsigned n, longint unsigned d);
        return int'((n + d / 2) / d);
    endfunction

    function automatic int unsigned gain_clamp(int unsigned x, int unsigned gain, int off);
        longint y;
        y = longint'((longint'(x) * gain + 128) >> 8) + off;
        if (y < 0) return 0;
        if (y > CMAX) return CMAX;
        return int'(y);
    endfunction

    // Compute the adjusted pixel for one input pixel
    function automatic hsva_pkg::t_pixel_out adjust_pixel(hsva_pkg::t_pixel_in px);
        hsva_pkg::t_pixel_out res;
        int unsigned r, g, b, mx, mn, d, h, s, v, fr, p, q, t, den;
        r = px.in_red; g = px.in_green; b = px.in_blue;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn; v = mx; h = 0; s = 0;
        den = CMAX * 256;
        if (d != 0) begin
            s = rdiv(d * CMAX, mx);
            if (mx == r) begin
                if (g >= b) h = rdiv((g - b) * 256, d);
                else h = 1536 - rdiv((b - g) * 256, d);
            end else if (mx == g) begin
                if (b >= r) h = 512 + rdiv((b - r) * 256, d);
                else h = 512 - rdiv((r - b) * 256, d);
            end else begin
                if (r >= g) h = 1024 + rdiv((r - g) * 256, d);
                else h = 1024 - rdiv((g - r) * 256, d);
            end
        end
        s = gain_clamp(s, sat_gain, sat_off);
        v = gain_clamp(v, val_gain, val_off);
        fr = h % 256;
        p = rdiv(v * (CMAX - s), CMAX);
        q = rdiv(longint'(v) * (den - s * fr), den);
        t = rdiv(longint'(v) * (den - s * (256 - fr)), den);
        case (h / 256)
            0: begin res.out_red = v; res.out_green = t; res.out_blue = p; end
            1: begin res.out_red = q; res.out_green = v; res.out_blue = p; end
            2: begin res.out_red = p; res.out_green = v; res.out_blue = t; end
            3: begin res.out_red = p; res.out_green = q; res.out_blue = v; end
            4: begin res.out_red = t; res.out_green = p; res.out_blue = v; end
            default: begin res.out_red = v; res.out_green = p; res.out_blue = q; end
        endcase
        res.out_alpha = px.in_alpha;
        return res;
    endfunction

    // Clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Driver: present pending items with random gaps
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            send_gap <= 0;
        end else if (in_taken) begin
            // item taken at the last rising edge
            void'(pending_pixels.pop_front());
            if (pending_pixels.size() > 0 && !sender_idle && $urandom_range(0, 3) == 0) begin
                i_valid <= 0;
                send_gap <= $urandom_range(0, 3);
            end else if (pending_pixels.size() > 0 && !sender_idle) begin
                i_data <= pending_pixels[0];
            end else begin
                i_valid <= 0;
            end
        end else if (!i_valid) begin
            if (send_gap > 0) send_gap <= send_gap - 1;
            else if (pending_pixels.size() > 0 && !sender_idle) begin
                i_valid <= 1;
                i_data <= pending_pixels[0];
            end
        end
    end

    // Predict at acceptance and flag the accept for the driver
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            expected_pixels = {expected_pixels, adjust_pixel(i_data)};
    end

    // Receiver stall pattern
    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1;
        end else if (cycles % 2000 < 600) begin
            i_stall <= 0;
        end else begin
            stall_left <= $urandom_range(0, 3);
            i_stall <= ($urandom_range(0, 1) == 1);
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        hsva_pkg::t_pixel_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            checked <= checked + 1;
            if (expected_pixels.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected result %h", o_data);
            end else begin
                want = expected_pixels.pop_front();
                if (want !== o_data) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: expected r%0d g%0d b%0d a%0d got r%0d g%0d b%0d a%0d",
                            want.out_red, want.out_green, want.out_blue, want.out_alpha,
                            o_data.out_red, o_data.out_green, o_data.out_blue,
                            o_data.out_alpha);
                end
            end
        end
    end

    task automatic add_pixel(int r, int g, int b, int a);
        hsva_pkg::t_pixel_in px;
        px.in_red = r; px.in_green = g; px.in_blue = b; px.in_alpha = a;
        pending_pixels = {pending_pixels, px};
    endtask

    // Let the pipeline drain; then hold extra cycles for its latency
    task automatic drain();
        while (pending_pixels.size() > 0 || i_valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            hsva_pkg::CFG_SAT_GAIN: sat_gain = value;
            hsva_pkg::CFG_SAT_OFF:  sat_off = $signed(value[8:0]);
            hsva_pkg::CFG_VAL_GAIN: val_gain = value;
            default:                val_off = $signed(value[8:0]);
        endcase
    endtask

    task automatic random_pixels(int count);
        int k;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 7))
                0: begin
                    int gv;
                    gv = $urandom_range(0, 255);
                    add_pixel(gv, gv, gv, $urandom_range(0, 255));
                end
                1: begin
                    int tv;
                    tv = $urandom_range(1, 255);
                    add_pixel(tv, tv, $urandom_range(0, 255), $urandom_range(0, 255));
                end
                default: add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 255));
            endcase
        end
    endtask

    // Configuration settings per phase: sat gain, sat offset, val gain, val offset
    int phase_sg[8] = '{256, 0,    4095, 512, 128, 300,  256, 200};
    int phase_so[8] = '{0,   255,  -255, 40,  -40, -256, 100, 0};
    int phase_vg[8] = '{256, 4095, 0,    128, 384, 256,  200, 700};
    int phase_vo[8] = '{0,   -255, 255,  -20, 30,  -256, 0,   -100};

    initial begin
        int ph;
        i_rst_n = 0; i_valid = 0; i_stall = 0; i_data = '0;
        i_cfg_we = 0; i_cfg_index = hsva_pkg::CFG_SAT_GAIN; i_cfg_data = '0;
        mismatches = 0; checked = 0; cycles = 0; sender_idle = 0;
        sat_gain = 256; sat_off = 0; val_gain = 256; val_off = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extremes, greys, hue ties and each sector
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 255);
        add_pixel(128, 128, 128, 170);
        add_pixel(255, 0, 0, 85);
        add_pixel(255, 255, 0, 1);
        add_pixel(0, 255, 0, 2);
        add_pixel(0, 255, 255, 3);
        add_pixel(0, 0, 255, 4);
        add_pixel(255, 0, 255, 5);
        add_pixel(255, 0, 1, 6);
        add_pixel(200, 200, 10, 7);
        add_pixel(10, 200, 200, 8);
        add_pixel(200, 10, 200, 9);
        add_pixel(1, 0, 0, 10);
        add_pixel(170, 85, 0, 11);
        add_pixel(85, 170, 255, 12);
        drain();

        // Random phases over the register settings, extremes included
        for (ph = 0; ph < 8; ph++) begin
            write_reg(hsva_pkg::CFG_SAT_GAIN, phase_sg[ph]);
            write_reg(hsva_pkg::CFG_SAT_OFF, phase_so[ph]);
            write_reg(hsva_pkg::CFG_VAL_GAIN, phase_vg[ph]);
            write_reg(hsva_pkg::CFG_VAL_OFF, phase_vo[ph]);
            add_pixel(255, 0, 128, 255);
            add_pixel(77, 77, 77, 0);
            random_pixels(170);
            if (ph == 3) begin
                // hold the sender until the pipeline is empty
                while (pending_pixels.size() > 90) @(posedge i_clk);
                sender_idle = 1;
                while (expected_pixels.size() > 0) @(posedge i_clk);
                @(negedge i_clk);
                sender_idle = 0;
            end
            drain();
        end

        $display("Checked %0d pixels over eight gain and offset settings,", checked);
        $display("with greys, hue ties, random gaps, output stalls and one full drain");
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
